/* rtl/pcps_pkg.sv */
// package for the per-client priority send scheduler: types and constants
package pcps_pkg;

  localparam int MAX_CLIENTS_DEF = 8;
  localparam int FIFO_DEPTH_DEF  = 32;
  localparam int NUM_CLASSES     = 3;
  localparam int LIMIT_W         = 6;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1
  } op_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_TABLE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_LIMIT_HIGH   = 2'd0,
    CFG_LIMIT_MIDDLE = 2'd1,
    CFG_LIMIT_LOW    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] client_id;
    logic [1:0]  priority_class;
    logic        is_inner;
    logic [31:0] message_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] message_out;
    logic        freed_full_fifo;
    logic        all_empty;
  } out_item_t;

endpackage

/* rtl/pcps_store.sv */
// message store memory: one synchronous ram, one write and one read port
module pcps_store import pcps_pkg::*; #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);
  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* rtl/per_client_priority_send_scheduler.sv */
// top level: send scheduler with per-client strict-priority fifos served round robin, inner fifos first
// a transaction accepted in idle steps through execute, store read and done; out_valid is
// registered from done, together with out_item
// busy is high from accept until the fsm is back in idle, so no new transaction is taken before then
// the fsm steps idle, execute, store read, done; the registered store read sets the pace
// reset: synchronous active-low rst_n clears counts, pointers, slot and ring state,
// limits go to 32; the message store itself is not cleared; results cannot be stalled
module per_client_priority_send_scheduler import pcps_pkg::*; #(
  parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [LIMIT_W-1:0]   cfg_data
);
  localparam int NF   = (MAX_CLIENTS + 1) * NUM_CLASSES;
  localparam int FW   = $clog2(NF);
  localparam int PW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW   = $clog2(FIFO_DEPTH + 1);
  localparam int SW   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int RCW  = $clog2(MAX_CLIENTS + 1);
  localparam int AW   = FW + PW;
  localparam int INNER_BASE = MAX_CLIENTS * NUM_CLASSES;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [LIMIT_W-1:0] limit_r [NUM_CLASSES];

  // fifo control state and client tables (small, kept in flops)
  logic [CW-1:0]  cnt_r [NF];
  logic [PW-1:0]  rp_r  [NF];
  logic [PW-1:0]  wp_r  [NF];
  logic [31:0]    slot_client_r [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] slot_valid_r;
  logic [SW-1:0]  ring_r [MAX_CLIENTS];
  logic [SW-1:0]  head_r;
  logic [RCW-1:0] rcount_r;

  in_item_t       item_r;
  logic [1:0]     status_r;
  logic           freed_r;
  logic           deq_pop_r;
  logic [31:0]    mout_r;
  logic           out_valid_r;
  out_item_t      out_r;

  // store port
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [31:0]   st_rdata;

  pcps_store #(.AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (item_r.message_handle),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  // class of the transaction, 2 and 3 both low
  logic [1:0] cls;
  assign cls = (item_r.priority_class[1]) ? 2'd2 : item_r.priority_class;

  function automatic logic [CW-1:0] eff_lim(input logic [LIMIT_W-1:0] v);
    logic [LIMIT_W:0] t;
    t = {1'b0, v};
    if (v == '0) t = (LIMIT_W+1)'(1);
    if (int'(t) > FIFO_DEPTH) return CW'(FIFO_DEPTH);
    return CW'(t);
  endfunction

  // ring tail slot: head plus count, wrapped once
  logic [RCW:0]  tail_sum;
  logic [SW-1:0] ring_tail;
  assign tail_sum  = (RCW+1)'(head_r) + (RCW+1)'(rcount_r);
  assign ring_tail = (tail_sum >= (RCW+1)'(MAX_CLIENTS)) ?
                     SW'(tail_sum - (RCW+1)'(MAX_CLIENTS)) : SW'(tail_sum);

  // client lookup over the slot table
  logic [SW-1:0] found_s, free_s;
  logic          found_v, free_v;
  always_comb begin
    found_s = '0; found_v = 1'b0; free_s = '0; free_v = 1'b0;
    for (int s = 0; s < MAX_CLIENTS; s++) begin
      if (slot_valid_r[s]) begin
        if (!found_v && slot_client_r[s] == item_r.client_id) begin
          found_v = 1'b1; found_s = SW'(s);
        end
      end else if (!free_v) begin
        free_v = 1'b1; free_s = SW'(s);
      end
    end
  end

  // dequeue selection
  logic          inner_any;
  logic [1:0]    inner_c;
  logic [SW-1:0] head_slot;
  logic          cl_any;
  logic [1:0]    cl_c;
  always_comb begin
    inner_any = 1'b0; inner_c = '0; cl_any = 1'b0; cl_c = '0;
    head_slot = ring_r[head_r];
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (cnt_r[INNER_BASE + c] != '0) begin
        inner_any = 1'b1; inner_c = 2'(c);
      end
      if (cnt_r[FW'(head_slot) * FW'(NUM_CLASSES) + FW'(c)] != '0) begin
        cl_any = 1'b1; cl_c = 2'(c);
      end
    end
  end

  logic inner_empty;
  always_comb begin
    inner_empty = 1'b1;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cnt_r[INNER_BASE + c] != '0) inner_empty = 1'b0;
    end
  end

  // execute-cycle decisions
  logic          do_push, do_pop, do_new, do_free, do_rot;
  logic [FW-1:0] tgt_f;
  logic [1:0]    st_nxt;
  logic          freed_nxt;
  always_comb begin
    do_push = 1'b0; do_pop = 1'b0; do_new = 1'b0; do_free = 1'b0; do_rot = 1'b0;
    tgt_f = '0; st_nxt = ST_OK; freed_nxt = 1'b0;
    if (item_r.operation == OP_ENQ[0]) begin
      if (item_r.client_id == '0 && item_r.is_inner) begin
        tgt_f = FW'(INNER_BASE) + FW'(cls);
        if (cnt_r[tgt_f] >= eff_lim(limit_r[cls])) st_nxt = ST_FULL;
        else do_push = 1'b1;
      end else if (found_v) begin
        tgt_f = FW'(found_s) * FW'(NUM_CLASSES) + FW'(cls);
        if (cnt_r[tgt_f] >= eff_lim(limit_r[cls])) st_nxt = ST_FULL;
        else do_push = 1'b1;
      end else if (!free_v || rcount_r >= RCW'(MAX_CLIENTS)) begin
        st_nxt = ST_TABLE;
      end else begin
        tgt_f = FW'(free_s) * FW'(NUM_CLASSES) + FW'(cls);
        do_new = 1'b1; do_push = 1'b1;
      end
    end else begin
      if (inner_any) begin
        tgt_f = FW'(INNER_BASE) + FW'(inner_c);
        do_pop = 1'b1;
      end else if (rcount_r == '0) begin
        st_nxt = ST_EMPTY;
      end else if (cl_any) begin
        tgt_f = FW'(head_slot) * FW'(NUM_CLASSES) + FW'(cl_c);
        do_pop = 1'b1; do_rot = 1'b1;
        freed_nxt = cnt_r[tgt_f] >= eff_lim(limit_r[cl_c]);
      end else begin
        st_nxt = ST_EMPTY; do_free = 1'b1;
      end
    end
  end

  logic exec;
  assign exec     = (state_r == S_EXEC);
  assign st_we    = exec && do_push;
  assign st_waddr = {tgt_f, (do_new ? PW'(0) : wp_r[tgt_f])};
  assign st_raddr = {tgt_f, rp_r[tgt_f]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_READ;
      S_READ:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      head_r       <= '0;
      rcount_r     <= '0;
      out_valid_r  <= 1'b0;
      for (int f = 0; f < NF; f++) begin
        cnt_r[f] <= '0; rp_r[f] <= '0; wp_r[f] <= '0;
      end
      for (int c = 0; c < NUM_CLASSES; c++) limit_r[c] <= LIMIT_W'(32);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_LIMIT_HIGH:   limit_r[0] <= cfg_data;
          CFG_LIMIT_MIDDLE: limit_r[1] <= cfg_data;
          CFG_LIMIT_LOW:    limit_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (exec) begin
        if (do_new) begin
          // fresh slot: all three fifos restart, the pushed class holds one entry
          slot_valid_r[free_s]  <= 1'b1;
          slot_client_r[free_s] <= item_r.client_id;
          for (int c = 0; c < NUM_CLASSES; c++) begin
            cnt_r[FW'(free_s) * FW'(NUM_CLASSES) + FW'(c)] <=
              (2'(c) == cls) ? CW'(1) : '0;
            rp_r[FW'(free_s) * FW'(NUM_CLASSES) + FW'(c)]  <= '0;
            wp_r[FW'(free_s) * FW'(NUM_CLASSES) + FW'(c)]  <=
              (2'(c) == cls) ? PW'(1 % FIFO_DEPTH) : '0;
          end
          ring_r[ring_tail] <= free_s;
          rcount_r <= rcount_r + 1'b1;
        end else if (do_push) begin
          cnt_r[tgt_f] <= cnt_r[tgt_f] + 1'b1;
          wp_r[tgt_f]  <= (wp_r[tgt_f] == PW'(FIFO_DEPTH - 1)) ? '0 : wp_r[tgt_f] + 1'b1;
        end
        if (do_pop) begin
          cnt_r[tgt_f] <= cnt_r[tgt_f] - 1'b1;
          rp_r[tgt_f]  <= (rp_r[tgt_f] == PW'(FIFO_DEPTH - 1)) ? '0 : rp_r[tgt_f] + 1'b1;
        end
        if (do_rot || do_free) begin
          head_r <= (head_r == SW'(MAX_CLIENTS - 1)) ? '0 : head_r + 1'b1;
        end
        if (do_rot) begin
          // head moves to the tail; count unchanged
          ring_r[ring_tail] <= head_slot;
        end
        if (do_free) begin
          rcount_r <= rcount_r - 1'b1;
          slot_valid_r[head_slot] <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) item_r <= in_item;
    if (exec) begin
      status_r  <= st_nxt;
      freed_r   <= freed_nxt;
      deq_pop_r <= do_pop;
    end
    if (state_r == S_READ) mout_r <= deq_pop_r ? st_rdata : '0;
    if (state_r == S_DONE) begin
      out_r.status          <= status_r;
      out_r.message_out     <= mout_r;
      out_r.freed_full_fifo <= freed_r;
      out_r.all_empty       <= inner_empty && (rcount_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  // a result strobe follows every accepted transaction
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##3 out_valid) else $error("missing result");
  // ring always holds exactly as many clients as slots marked valid
  a_ring: assert property (@(posedge clk) disable iff (!rst_n)
    rcount_r == RCW'($countones(slot_valid_r))) else $error("ring and slots disagree");
  // a freed-full flag only comes with a successful dequeue
  a_freed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.freed_full_fifo) |-> (out_item.status == ST_OK))
    else $error("freed flag without dequeue");
`endif
endmodule

/* bench/tb.sv */
// testbench for the per-client priority send scheduler: directed table, then random traffic
module tb;
  import pcps_pkg::*;

  localparam int NCLI   = 8;
  localparam int DEPTH  = 32;
  localparam int NFIFO  = (NCLI + 1) * NUM_CLASSES;
  localparam int INNER0 = NCLI * NUM_CLASSES;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [LIMIT_W-1:0]   cfg_data;

  per_client_priority_send_scheduler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // shadow copy of the scheduler state
  logic [31:0] msg_mem [NFIFO][DEPTH];
  int          fcount [NFIFO];
  int          rptr [NFIFO];
  int          wptr [NFIFO];
  logic [31:0] owner [NCLI];
  bit          owned [NCLI];
  int          rr_slot [NCLI];
  int          rr_head;
  int          rr_count;
  logic [5:0]  class_limit [NUM_CLASSES];

  out_item_t   pending_results [$];
  int          errors;
  int          cycles;

  // a limit of zero behaves as one, anything past the depth as the depth
  function automatic int eff_cap(int c);
    int v;
    v = class_limit[c];
    if (v == 0) v = 1;
    if (v > DEPTH) v = DEPTH;
    return v;
  endfunction

  function automatic void push_msg(int f, logic [31:0] v);
    msg_mem[f][wptr[f]] = v;
    wptr[f] = (wptr[f] + 1) % DEPTH;
    fcount[f]++;
  endfunction

  function automatic logic [31:0] pop_msg(int f);
    logic [31:0] v;
    v = msg_mem[f][rptr[f]];
    rptr[f] = (rptr[f] + 1) % DEPTH;
    fcount[f]--;
    return v;
  endfunction

  // one scheduler step: updates the shadow state, returns the expected result
  function automatic out_item_t sched_predict(in_item_t it);
    out_item_t r;
    int cls, s, f, c, found, freeslot, slot;
    bit done, inner_idle;
    r = '0;
    cls = (it.priority_class >= 2) ? 2 : it.priority_class;
    if (it.operation == OP_ENQ[0]) begin
      found = NCLI;
      freeslot = NCLI;
      if (it.client_id == 0 && it.is_inner) begin
        f = INNER0 + cls;
        if (fcount[f] >= eff_cap(cls)) r.status = ST_FULL;
        else begin
          push_msg(f, it.message_handle);
          r.status = ST_OK;
        end
      end else begin
        for (s = 0; s < NCLI; s++) begin
          if (owned[s]) begin
            if (found == NCLI && owner[s] == it.client_id) found = s;
          end else if (freeslot == NCLI) begin
            freeslot = s;
          end
        end
        if (found < NCLI) begin
          f = found * NUM_CLASSES + cls;
          if (fcount[f] >= eff_cap(cls)) r.status = ST_FULL;
          else begin
            push_msg(f, it.message_handle);
            r.status = ST_OK;
          end
        end else if (freeslot >= NCLI || rr_count >= NCLI) begin
          r.status = ST_TABLE;
        end else begin
          // new client: fresh fifos, joins the ring tail
          owned[freeslot] = 1;
          owner[freeslot] = it.client_id;
          for (c = 0; c < NUM_CLASSES; c++) begin
            fcount[freeslot * NUM_CLASSES + c] = 0;
            rptr[freeslot * NUM_CLASSES + c] = 0;
            wptr[freeslot * NUM_CLASSES + c] = 0;
          end
          rr_slot[(rr_head + rr_count) % NCLI] = freeslot;
          rr_count++;
          push_msg(freeslot * NUM_CLASSES + cls, it.message_handle);
          r.status = ST_OK;
        end
      end
    end else begin
      done = 0;
      // inner queue first, strict priority
      for (c = 0; c < NUM_CLASSES; c++) begin
        if (!done && fcount[INNER0 + c] != 0) begin
          r.message_out = pop_msg(INNER0 + c);
          r.status = ST_OK;
          done = 1;
        end
      end
      if (!done) begin
        if (rr_count == 0) r.status = ST_EMPTY;
        else begin
          slot = rr_slot[rr_head];
          rr_head = (rr_head + 1) % NCLI;
          rr_count--;
          for (c = 0; c < NUM_CLASSES; c++) begin
            f = slot * NUM_CLASSES + c;
            if (!done && fcount[f] != 0) begin
              r.freed_full_fifo = (fcount[f] >= eff_cap(c));
              r.message_out = pop_msg(f);
              rr_slot[(rr_head + rr_count) % NCLI] = slot;
              rr_count++;
              r.status = ST_OK;
              done = 1;
            end
          end
          // empty head client is dropped from the table
          if (!done) begin
            owned[slot] = 0;
            r.status = ST_EMPTY;
          end
        end
      end
    end
    inner_idle = 1;
    for (c = 0; c < NUM_CLASSES; c++) if (fcount[INNER0 + c] != 0) inner_idle = 0;
    r.all_empty = inner_idle && rr_count == 0;
    return r;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result checker: every strobe must match the oldest pending transaction
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d", out_item.status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_item.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_item.status);
          errors++;
        end
        if (out_item.message_out !== e.message_out) begin
          $error("message_out expected %h actual %h", e.message_out, out_item.message_out);
          errors++;
        end
        if (out_item.freed_full_fifo !== e.freed_full_fifo) begin
          $error("freed_full_fifo expected %0d actual %0d", e.freed_full_fifo,
                 out_item.freed_full_fifo);
          errors++;
        end
        if (out_item.all_empty !== e.all_empty) begin
          $error("all_empty expected %0d actual %0d", e.all_empty, out_item.all_empty);
          errors++;
        end
      end
    end
  end

  // drive one transaction, hold start until accepted, then a random idle gap that may be empty
  task automatic send_item(in_item_t it, bit fixed, logic [1:0] fixed_status);
    out_item_t e;
    int gap;
    in_item = it;
    start = 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    e = sched_predict(it);
    if (fixed) e.status = fixed_status;
    pending_results.push_back(e);
    @(negedge clk);
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // limits are only touched once the block has drained
  task automatic write_limits(logic [5:0] hi, logic [5:0] mid, logic [5:0] lo);
    logic [5:0] v [NUM_CLASSES];
    int i;
    v[0] = hi; v[1] = mid; v[2] = lo;
    start = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    for (i = 0; i < NUM_CLASSES; i++) begin
      cfg_we = 1;
      cfg_idx = (i == 0) ? CFG_LIMIT_HIGH : (i == 1) ? CFG_LIMIT_MIDDLE : CFG_LIMIT_LOW;
      cfg_data = v[i];
      class_limit[i] = v[i];
      @(negedge clk);
    end
    cfg_we = 0;
  endtask

  typedef struct {
    bit          deq;
    logic [31:0] client;
    logic [1:0]  pc;
    bit          inner;
    logic [31:0] handle;
    bit          fixed;
    logic [1:0]  st;
  } stim_row_t;

  stim_row_t directed [] = '{
    // dequeue right after reset: nothing anywhere
    '{1, 32'h0, 2'd0, 0, 32'h0, 1, ST_EMPTY},
    // inner messages, high and low classes incl. the low alias
    '{0, 32'h0, 2'd2, 1, 32'hFFFFFFFF, 1, ST_OK},
    '{0, 32'h0, 2'd0, 1, 32'h00000000, 1, ST_OK},
    '{0, 32'h0, 2'd3, 1, 32'hA5A5A5A5, 1, ST_OK},
    // client 0 without the inner mark is an ordinary client
    '{0, 32'h0, 2'd1, 0, 32'h12345678, 1, ST_OK},
    '{0, 32'hFFFFFFFF, 2'd3, 1, 32'h5A5A5A5A, 1, ST_OK},
    '{0, 32'h1, 2'd0, 0, 32'h1, 1, ST_OK},
    '{0, 32'h2, 2'd1, 0, 32'h2, 1, ST_OK},
    '{0, 32'h3, 2'd2, 0, 32'h3, 1, ST_OK},
    '{0, 32'h4, 2'd0, 0, 32'h4, 1, ST_OK},
    '{0, 32'h5, 2'd0, 0, 32'h5, 1, ST_OK},
    '{0, 32'h6, 2'd0, 0, 32'h6, 1, ST_OK},
    // ninth client finds no free slot
    '{0, 32'h7, 2'd0, 0, 32'h7, 1, ST_TABLE},
    '{0, 32'h1, 2'd2, 0, 32'h11, 0, 2'd0},
    // drain: inner first, then the ring
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0},
    '{1, 32'h0, 2'd0, 0, 32'h0, 0, 2'd0}
  };

  // setting per random phase: zero, one, depth and above-depth limits
  logic [5:0] phase_lim [6][3] = '{
    '{6'd1, 6'd1, 6'd1}, '{6'd0, 6'd63, 6'd3}, '{6'd32, 6'd2, 6'd0},
    '{6'd4, 6'd33, 6'd1}, '{6'd63, 6'd0, 6'd32}, '{6'd32, 6'd32, 6'd32}
  };

  initial begin
    in_item_t it;
    int i, p, n, enq_pct;
    logic [31:0] pool [10];
    rst_n = 0;
    start = 0;
    in_item = '0;
    cfg_we = 0;
    cfg_idx = CFG_LIMIT_HIGH;
    cfg_data = '0;
    for (i = 0; i < NFIFO; i++) begin
      fcount[i] = 0; rptr[i] = 0; wptr[i] = 0;
    end
    for (i = 0; i < NCLI; i++) begin
      owned[i] = 0; owner[i] = '0; rr_slot[i] = 0;
    end
    rr_head = 0;
    rr_count = 0;
    for (i = 0; i < NUM_CLASSES; i++) class_limit[i] = 6'd32;
    repeat (4) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed table
    foreach (directed[k]) begin
      it = '0;
      it.operation = directed[k].deq ? OP_DEQ[0] : OP_ENQ[0];
      it.client_id = directed[k].client;
      it.priority_class = directed[k].pc;
      it.is_inner = directed[k].inner;
      it.message_handle = directed[k].handle;
      send_item(it, directed[k].fixed, directed[k].st);
    end

    // random phases over a small client pool so the table fills and clients churn
    for (p = 0; p < 6; p++) begin
      write_limits(phase_lim[p][0], phase_lim[p][1], phase_lim[p][2]);
      for (i = 0; i < 10; i++) pool[i] = (i == 0) ? 32'h0 : $urandom();
      for (n = 0; n < 180; n++) begin
        // alternate fill-heavy and drain-heavy stretches
        enq_pct = ((n / 45) % 2 == 0) ? 70 : 35;
        it = '0;
        it.operation = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ[0] : OP_DEQ[0];
        it.client_id = ($urandom_range(0, 19) == 0) ? $urandom() : pool[$urandom_range(0, 9)];
        it.priority_class = 2'($urandom_range(0, 3));
        it.is_inner = 1'($urandom_range(0, 1));
        it.message_handle = $urandom();
        send_item(it, 0, 2'd0);
      end
    end

    start = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* per_client_priority_send_scheduler.f */
rtl/pcps_pkg.sv
rtl/pcps_store.sv
rtl/per_client_priority_send_scheduler.sv
bench/tb.sv
